[design/dwc_pkg.sv]
package dwc_pkg;

	// default sizes of the stores
	localparam int DEF_MAX_ROWS   = 64;
	localparam int DEF_MAX_COLS   = 64;
	localparam int DEF_KERNEL_DIM = 3;

	// width of signed window positions (row plus kernel offset)
	localparam int POS_W = 9;

	// int16 saturation bounds
	localparam int SAT_HIGH = 32767;
	localparam int SAT_LOW  = -32768;

	// request kinds carried in tuser
	localparam logic [1:0] REQ_TAP   = 2'd0;
	localparam logic [1:0] REQ_BIAS  = 2'd1;
	localparam logic [1:0] REQ_PIXEL = 2'd2;
	localparam logic [1:0] REQ_QUERY = 2'd3;

	// result status codes
	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_SAT     = 2'd1;
	localparam logic [1:0] STATUS_OUTSIDE = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_HEIGHT  = 2'd0;
	localparam logic [1:0] CFG_WIDTH   = 2'd1;
	localparam logic [1:0] CFG_PADDING = 2'd2;

	// configuration reset values
	localparam logic [6:0] RST_HEIGHT  = 7'd64;
	localparam logic [6:0] RST_WIDTH   = 7'd64;
	localparam logic       RST_PADDING = 1'b1;

	// query sequencer
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FLUSH,
		ST_DONE
	} seq_state_t;

	// control from the sequencer to the multiply-accumulate unit
	typedef struct packed {
		logic init;
		logic take;
	} mac_ctl_t;

endpackage

[design/dwc_mac.sv]
module dwc_mac #(
	parameter int ACC_W = 38
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dwc_pkg::mac_ctl_t    ctl,
	input  logic signed [15:0]   bias,
	input  logic signed [15:0]   pix,
	input  logic signed [15:0]   tap,
	output logic signed [15:0]   sat_value,
	output logic                 sat_flag
);
	import dwc_pkg::*;

	localparam logic signed [ACC_W-1:0] ACC_HIGH = ACC_W'(SAT_HIGH);
	localparam logic signed [ACC_W-1:0] ACC_LOW  = ACC_W'(SAT_LOW);

	logic signed [31:0]      prod_s2;
	logic                    vld_s2;
	logic signed [ACC_W-1:0] acc_q;

	// product stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= ctl.take;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= pix * tap;
	end

	// accumulator, loaded with the bias at the start of a query
	always_ff @(posedge clk) begin
		if (ctl.init) begin
			acc_q <= ACC_W'(bias);
		end else if (vld_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	// clamp to int16
	always_comb begin
		sat_flag  = 1'b0;
		sat_value = acc_q[15:0];
		if (acc_q > ACC_HIGH) begin
			sat_flag  = 1'b1;
			sat_value = 16'(SAT_HIGH);
		end else if (acc_q < ACC_LOW) begin
			sat_flag  = 1'b1;
			sat_value = 16'(SAT_LOW);
		end
	end

	// bias load and a product never land on the accumulator together
	a_init_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.init |-> !vld_s2)
		else $error("accumulator init collides with a product");

	// a pending product always follows a take in the previous cycle
	a_take_to_vld: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.take |=> vld_s2)
		else $error("product stage lost a take");

	a_vld_from_take: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> $past(ctl.take))
		else $error("product stage valid without a take");

endmodule

[design/depthwise_conv_3x3_saturating_top.sv]
// channel  | direction | handshake                   | payload
// s_axis   | in        | s_axis_tvalid/s_axis_tready | tdata: tap, row, col, data; tuser: kind
// m_axis   | out       | m_axis_tvalid/m_axis_tready | tdata: result; tuser: status
// cfg      | in        | cfg_valid/cfg_ready         | cfg_index, cfg_data
//
// loads (tap, bias, pixel) are accepted only while the sequencer is idle and give no result.
// a query in the plane closes the input while the sequencer steps through each window
// tap through the single shared multiplier, drains the product and accumulator stages
// and loads the result; a query outside the plane closes it until its result is loaded.
// the result register stalls the sequencer only if a previous result is still untaken.
// reset clears control and configuration; the pixel and tap memories are not cleared.
module depthwise_conv_3x3_saturating_top #(
	parameter int MAX_ROWS   = dwc_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS   = dwc_pkg::DEF_MAX_COLS,
	parameter int KERNEL_DIM = dwc_pkg::DEF_KERNEL_DIM
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // tap_index[3:0], row_pos[9:4], col_pos[15:10], data_value[31:16]
	input  logic [1:0]  s_axis_tuser,  // req_type[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // result_value[15:0]
	output logic [1:0]  m_axis_tuser,  // status[1:0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [6:0]  cfg_data
);
	import dwc_pkg::*;

	localparam int TAP_COUNT = KERNEL_DIM * KERNEL_DIM;
	localparam int TW        = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
	localparam int KCW       = (KERNEL_DIM > 1) ? $clog2(KERNEL_DIM) : 1;
	localparam int DEPTH     = MAX_ROWS * MAX_COLS;
	localparam int AW        = $clog2(DEPTH);
	localparam int ACC_W     = 33 + $clog2(TAP_COUNT + 1);
	localparam int PAD       = (KERNEL_DIM - 1) / 2;

	// input fields
	logic [3:0]         in_tap;
	logic [5:0]         in_row;
	logic [5:0]         in_col;
	logic signed [15:0] in_data;
	logic [1:0]         in_req;
	logic               in_acc;

	assign in_tap  = s_axis_tdata[3:0];
	assign in_row  = s_axis_tdata[9:4];
	assign in_col  = s_axis_tdata[15:10];
	assign in_data = s_axis_tdata[31:16];
	assign in_req  = s_axis_tuser;
	assign in_acc  = s_axis_tvalid && s_axis_tready;

	// configuration registers
	logic [6:0] height_q;
	logic [6:0] width_q;
	logic       same_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q <= RST_HEIGHT;
			width_q  <= RST_WIDTH;
			same_q   <= RST_PADDING;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_HEIGHT:  height_q <= cfg_data;
				CFG_WIDTH:   width_q  <= cfg_data;
				CFG_PADDING: same_q   <= cfg_data[0];
				default:     ;
			endcase
		end
	end

	// plane dimensions clamped to the store, output plane extent
	logic [6:0]              h_c;
	logic [6:0]              w_c;
	logic signed [POS_W-1:0] oh_c;
	logic signed [POS_W-1:0] ow_c;
	logic [POS_W-1:0]        pad_c;
	logic                    outside_c;

	always_comb begin
		h_c = height_q;
		w_c = width_q;
		if (32'(height_q) > MAX_ROWS) begin
			h_c = 7'(MAX_ROWS);
		end
		if (32'(width_q) > MAX_COLS) begin
			w_c = 7'(MAX_COLS);
		end
		pad_c = same_q ? POS_W'(PAD) : '0;
		oh_c  = same_q ? signed'(POS_W'(h_c)) : signed'(POS_W'(h_c) - POS_W'(KERNEL_DIM - 1));
		ow_c  = same_q ? signed'(POS_W'(w_c)) : signed'(POS_W'(w_c) - POS_W'(KERNEL_DIM - 1));
		outside_c = (oh_c <= 0) || (ow_c <= 0) ||
			(signed'(POS_W'(in_row)) >= oh_c) || (signed'(POS_W'(in_col)) >= ow_c);
	end

	// sequencer registers
	seq_state_t     state_q;
	seq_state_t     state_d;
	logic [KCW-1:0] kh_q;
	logic [KCW-1:0] kw_q;
	logic [TW-1:0]  tidx_q;
	logic           flush_q;
	logic [5:0]     row_q;
	logic [5:0]     col_q;
	logic           outside_q;
	logic           last_tap;
	logic           issue;
	logic           query_acc;
	logic           out_load;

	assign query_acc = in_acc && (in_req == REQ_QUERY);
	assign last_tap  = (kh_q == KCW'(KERNEL_DIM - 1)) && (kw_q == KCW'(KERNEL_DIM - 1));

	// next state and sequencer outputs
	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		issue         = 1'b0;
		out_load      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (query_acc) begin
					state_d = outside_c ? ST_DONE : ST_RUN;
				end
			end
			ST_RUN: begin
				issue = 1'b1;
				if (last_tap) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (flush_q) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!m_axis_tvalid || m_axis_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// window counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kh_q    <= '0;
			kw_q    <= '0;
			tidx_q  <= '0;
			flush_q <= 1'b0;
		end else begin
			if (query_acc) begin
				kh_q   <= '0;
				kw_q   <= '0;
				tidx_q <= '0;
			end else if (issue && !last_tap) begin
				tidx_q <= tidx_q + 1'b1;
				if (kw_q == KCW'(KERNEL_DIM - 1)) begin
					kw_q <= '0;
					kh_q <= kh_q + 1'b1;
				end else begin
					kw_q <= kw_q + 1'b1;
				end
			end
			flush_q <= (state_q == ST_FLUSH) && !flush_q;
		end
	end

	// query position held for the whole window
	always_ff @(posedge clk) begin
		if (query_acc) begin
			row_q     <= in_row;
			col_q     <= in_col;
			outside_q <= outside_c;
		end
	end

	// window position and bounds check for the current tap
	logic signed [POS_W-1:0] ih;
	logic signed [POS_W-1:0] iw;
	logic                    in_plane;
	logic [AW-1:0]           rd_addr;
	logic [AW-1:0]           wr_addr;
	logic                    pix_we;
	logic                    tap_we;

	assign ih = signed'(POS_W'(row_q) + POS_W'(kh_q) - pad_c);
	assign iw = signed'(POS_W'(col_q) + POS_W'(kw_q) - pad_c);
	assign in_plane = (ih >= 0) && (ih < signed'(POS_W'(h_c))) &&
		(iw >= 0) && (iw < signed'(POS_W'(w_c)));
	assign rd_addr = AW'(AW'(ih[POS_W-2:0]) * AW'(MAX_COLS)) + AW'(iw[POS_W-2:0]);
	assign wr_addr = AW'(AW'(in_row) * AW'(MAX_COLS)) + AW'(in_col);

	assign pix_we = in_acc && (in_req == REQ_PIXEL) &&
		(32'(in_row) < MAX_ROWS) && (32'(in_col) < MAX_COLS);
	assign tap_we = in_acc && (in_req == REQ_TAP) && (32'(in_tap) < TAP_COUNT);

	// plane and tap memories, registered read
	logic signed [15:0] plane_mem [DEPTH];
	logic signed [15:0] tap_mem [TAP_COUNT];
	logic signed [15:0] pix_s1;
	logic signed [15:0] tap_s1;
	logic               vld_s1;

	always_ff @(posedge clk) begin
		if (pix_we) begin
			plane_mem[wr_addr] <= in_data;
		end
		pix_s1 <= plane_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (tap_we) begin
			tap_mem[TW'(in_tap)] <= in_data;
		end
		tap_s1 <= tap_mem[tidx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= issue && in_plane;
		end
	end

	// channel bias
	logic signed [15:0] bias_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_q <= '0;
		end else if (in_acc && (in_req == REQ_BIAS)) begin
			bias_q <= in_data;
		end
	end

	// shared multiply-accumulate
	mac_ctl_t           mac_ctl;
	logic signed [15:0] sat_value;
	logic               sat_flag;

	assign mac_ctl.init = query_acc;
	assign mac_ctl.take = vld_s1;

	dwc_mac #(
		.ACC_W(ACC_W)
	) u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (mac_ctl),
		.bias     (bias_q),
		.pix      (pix_s1),
		.tap      (tap_s1),
		.sat_value(sat_value),
		.sat_flag (sat_flag)
	);

	// result register
	logic        out_valid_q;
	logic [15:0] out_data_q;
	logic [1:0]  out_status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (outside_q) begin
				out_data_q   <= '0;
				out_status_q <= STATUS_OUTSIDE;
			end else begin
				out_data_q   <= sat_value;
				out_status_q <= sat_flag ? STATUS_SAT : STATUS_OK;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_status_q;

	// a query transaction closes the input until its result is loaded
	a_query_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && s_axis_tuser == REQ_QUERY) |=> !s_axis_tready)
		else $error("input reopened straight after a query");

	// saturated results sit on a bound
	a_sat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == STATUS_SAT) |->
		(m_axis_tdata == 16'h7fff || m_axis_tdata == 16'h8000))
		else $error("saturated result not at a bound");

	// positions outside the output plane report zero
	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == STATUS_OUTSIDE) |-> (m_axis_tdata == 16'h0000))
		else $error("outside result not zero");

	// a result is never loaded over one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && m_axis_tvalid) |-> m_axis_tready)
		else $error("result overwritten before transaction");

endmodule

[test/depthwise_conv_3x3_saturating_top_tb.sv]
`timescale 1ns / 100ps

module depthwise_conv_3x3_saturating_top_tb;
	import dwc_pkg::*;

	localparam int MAX_ROWS = DEF_MAX_ROWS;
	localparam int MAX_COLS = DEF_MAX_COLS;
	localparam int KDIM     = DEF_KERNEL_DIM;
	localparam int TAPS     = KDIM * KDIM;
	localparam logic [1:0] CFG_UNUSED = 2'd3;

	// one input transaction
	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  tap;
		logic [5:0]  row;
		logic [5:0]  col;
		logic [15:0] value;
	} conv_req_t;

	// one output transaction
	typedef struct packed {
		logic [15:0] value;
		logic [1:0]  status;
	} conv_res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;  // tap_index[3:0], row_pos[9:4], col_pos[15:10], data_value[31:16]
	logic [1:0]  s_axis_tuser = '0;  // req_type[1:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;  // result_value[15:0]
	logic [1:0]  m_axis_tuser;  // status[1:0]
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [6:0]  cfg_data = '0;

	// predicted state of the block
	logic signed [15:0] plane_mem [0:MAX_ROWS*MAX_COLS-1];
	logic signed [15:0] tap_mem [0:TAPS-1];
	logic signed [15:0] bias_mem = '0;
	logic [6:0]         cfg_h = RST_HEIGHT;
	logic [6:0]         cfg_w = RST_WIDTH;
	logic               cfg_same = RST_PADDING;

	// stimulus bookkeeping
	bit        pix_seen [0:MAX_ROWS*MAX_COLS-1];
	conv_req_t req_queue[$];
	conv_res_t results_due[$];
	conv_req_t cur_req;
	logic      in_fire = 1'b0;
	bit        steady = 1'b0;
	bit        wide_values = 1'b0;
	int        hold_cycles = 0;
	int        stim_count = 0;
	int        settings = 0;
	int        mismatches = 0;
	int        ok_count = 0;
	int        sat_count = 0;
	int        outside_count = 0;

	depthwise_conv_3x3_saturating_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// geometry of the plane and of the output plane
	function automatic int plane_rows();
		return (cfg_h > MAX_ROWS) ? MAX_ROWS : int'(cfg_h);
	endfunction

	function automatic int plane_cols();
		return (cfg_w > MAX_COLS) ? MAX_COLS : int'(cfg_w);
	endfunction

	function automatic int out_rows();
		return cfg_same ? plane_rows() : plane_rows() - KDIM + 1;
	endfunction

	function automatic int out_cols();
		return cfg_same ? plane_cols() : plane_cols() - KDIM + 1;
	endfunction

	function automatic bit in_out_plane(input int row, input int col);
		return row < out_rows() && col < out_cols();
	endfunction

	// update the state for one accepted transaction, queue the result of a query
	function automatic void apply_request(input conv_req_t rq);
		conv_res_t res;
		longint    acc;
		int        pad, ih, iw, kh, kw;
		case (rq.kind)
			REQ_TAP: begin
				if (rq.tap < TAPS)
					tap_mem[rq.tap] = rq.value;
			end
			REQ_BIAS: begin
				bias_mem = rq.value;
			end
			REQ_PIXEL: begin
				plane_mem[int'(rq.row) * MAX_COLS + int'(rq.col)] = rq.value;
			end
			REQ_QUERY: begin
				if (!in_out_plane(int'(rq.row), int'(rq.col))) begin
					res.value = '0;
					res.status = STATUS_OUTSIDE;
				end else begin
					pad = cfg_same ? (KDIM - 1) / 2 : 0;
					acc = bias_mem;
					for (kh = 0; kh < KDIM; kh++) begin
						for (kw = 0; kw < KDIM; kw++) begin
							ih = int'(rq.row) + kh - pad;
							iw = int'(rq.col) + kw - pad;
							if (ih >= 0 && ih < plane_rows() && iw >= 0 && iw < plane_cols())
								acc += longint'(plane_mem[ih * MAX_COLS + iw]) *
									longint'(tap_mem[kh * KDIM + kw]);
						end
					end
					res.status = STATUS_OK;
					if (acc > SAT_HIGH) begin
						acc = SAT_HIGH;
						res.status = STATUS_SAT;
					end else if (acc < SAT_LOW) begin
						acc = SAT_LOW;
						res.status = STATUS_SAT;
					end
					res.value = acc[15:0];
				end
				results_due.push_back(res);
			end
			default: ;
		endcase
	endfunction

	// values: mostly small, some extremes, full range in wide phases
	function automatic logic [15:0] pick_value();
		int sel;
		sel = $urandom_range(99);
		if (sel < 8) begin
			case ($urandom_range(4))
				0: return 16'(SAT_HIGH);
				1: return 16'(SAT_LOW);
				2: return 16'd0;
				3: return 16'd1;
				default: return 16'hffff;
			endcase
		end
		if (wide_values && sel < 60)
			return 16'($urandom);
		return 16'(int'($urandom_range(120)) - 60);
	endfunction

	function automatic logic [6:0] pick_dim();
		int sel;
		sel = $urandom_range(19);
		if (sel < 12)
			return 7'($urandom_range(8, 1));
		if (sel < 16)
			return 7'($urandom_range(64, 9));
		if (sel < 18) begin
			case ($urandom_range(3))
				0: return 7'd0;
				1: return 7'd2;
				2: return 7'd3;
				default: return 7'd64;
			endcase
		end
		return 7'($urandom_range(127, 65));
	endfunction

	function automatic void push_req(input logic [1:0] kind, input logic [3:0] tap,
		input logic [5:0] row, input logic [5:0] col, input logic [15:0] value);
		conv_req_t rq;
		rq.kind = kind;
		rq.tap = tap;
		rq.row = row;
		rq.col = col;
		rq.value = value;
		req_queue.push_back(rq);
		if (kind == REQ_PIXEL)
			pix_seen[int'(row) * MAX_COLS + int'(col)] = 1'b1;
		if (!(kind == REQ_TAP && tap >= TAPS))
			stim_count++;
	endfunction

	// query preceded by writes of any window pixel not yet written, and some rewrites
	function automatic void add_query(input int row, input int col);
		int pad, ih, iw, kh, kw;
		pad = cfg_same ? (KDIM - 1) / 2 : 0;
		if (in_out_plane(row, col)) begin
			for (kh = 0; kh < KDIM; kh++) begin
				for (kw = 0; kw < KDIM; kw++) begin
					ih = row + kh - pad;
					iw = col + kw - pad;
					if (ih >= 0 && ih < plane_rows() && iw >= 0 && iw < plane_cols() &&
						(!pix_seen[ih * MAX_COLS + iw] || $urandom_range(3) == 0))
						push_req(REQ_PIXEL, 4'($urandom), 6'(ih), 6'(iw), pick_value());
				end
			end
		end
		push_req(REQ_QUERY, 4'($urandom), 6'(row), 6'(col), 16'($urandom));
	endfunction

	task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CFG_HEIGHT: cfg_h = val;
			CFG_WIDTH: cfg_w = val;
			CFG_PADDING: cfg_same = val[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_geometry(input logic [6:0] h, input logic [6:0] w, input logic mode);
		write_reg(CFG_HEIGHT, h);
		write_reg(CFG_WIDTH, w);
		write_reg(CFG_PADDING, {6'($urandom), mode});
		settings++;
	endtask

	// hold the sender until every result is in and the block has settled
	task automatic wait_drained();
		while (req_queue.size() > 0 || s_axis_tvalid || results_due.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// input driver
	always @(negedge clk) begin
		if (arst_n && (!s_axis_tvalid || in_fire)) begin
			if (req_queue.size() > 0 && (steady || $urandom_range(99) >= 20)) begin
				cur_req = req_queue.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {cur_req.value, cur_req.col, cur_req.row, cur_req.tap};
				s_axis_tuser <= cur_req.kind;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// input transaction accepted: predict
	always @(posedge clk) begin
		in_fire <= s_axis_tvalid && s_axis_tready;
		if (arst_n && s_axis_tvalid && s_axis_tready)
			apply_request(cur_req);
	end

	// receiver back-pressure, with a long hold when requested
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			m_axis_tready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else begin
			m_axis_tready <= steady || $urandom_range(99) >= 20;
		end
	end

	// output transaction check
	always @(posedge clk) begin : result_check
		conv_res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (results_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: value %0d status %0d",
						$signed(m_axis_tdata), m_axis_tuser);
			end else begin
				want = results_due.pop_front();
				if (m_axis_tdata !== want.value || m_axis_tuser !== want.status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected value %0d status %0d, got value %0d status %0d",
							$signed(want.value), want.status,
							$signed(m_axis_tdata), m_axis_tuser);
				end
				case (want.status)
					STATUS_OK: ok_count++;
					STATUS_SAT: sat_count++;
					default: outside_count++;
				endcase
			end
		end
	end

	// stimulus
	initial begin
		int phase, units, sel;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset geometry: taps at the extremes, an ignored tap, saturation both ways
		for (int t = 0; t < TAPS; t++)
			push_req(REQ_TAP, 4'(t), 6'd0, 6'd0,
				(t == 0) ? 16'(SAT_LOW) : (t == TAPS - 1) ? 16'(SAT_HIGH) : 16'd1);
		push_req(REQ_TAP, 4'd15, 6'd0, 6'd0, 16'h3039);
		push_req(REQ_BIAS, 4'd0, 6'd0, 6'd0, 16'(SAT_HIGH));
		push_req(REQ_PIXEL, 4'd0, 6'd0, 6'd0, 16'(SAT_HIGH));
		push_req(REQ_PIXEL, 4'd0, 6'd0, 6'd1, 16'd0);
		push_req(REQ_PIXEL, 4'd0, 6'd1, 6'd0, 16'd0);
		push_req(REQ_PIXEL, 4'd0, 6'd1, 6'd1, 16'(SAT_HIGH));
		push_req(REQ_QUERY, 4'd0, 6'd0, 6'd0, 16'd0);
		push_req(REQ_PIXEL, 4'd0, 6'd62, 6'd62, 16'(SAT_HIGH));
		push_req(REQ_PIXEL, 4'd0, 6'd62, 6'd63, 16'd0);
		push_req(REQ_PIXEL, 4'd0, 6'd63, 6'd62, 16'd0);
		push_req(REQ_PIXEL, 4'd0, 6'd63, 6'd63, 16'hffff);
		push_req(REQ_QUERY, 4'd0, 6'd63, 6'd63, 16'd0);
		push_req(REQ_BIAS, 4'd0, 6'd0, 6'd0, 16'd0);
		push_req(REQ_PIXEL, 4'd0, 6'd62, 6'd62, 16'd0);
		push_req(REQ_QUERY, 4'd15, 6'd63, 6'd63, 16'hffff);
		wait_drained();

		// zero sizes, small plane without padding, oversized sizes, single pixel
		set_geometry(7'd0, 7'd5, 1'b1);
		add_query(0, 0);
		add_query(63, 63);
		wait_drained();
		set_geometry(7'd5, 7'd0, 1'b0);
		add_query(0, 0);
		wait_drained();
		set_geometry(7'd2, 7'd64, 1'b0);
		add_query(0, 0);
		add_query(1, 5);
		wait_drained();
		set_geometry(7'd127, 7'd100, 1'b0);
		add_query(61, 61);
		add_query(62, 0);
		add_query(0, 62);
		wait_drained();
		set_geometry(7'd3, 7'd3, 1'b0);
		add_query(0, 0);
		add_query(0, 1);
		wait_drained();
		set_geometry(7'd1, 7'd1, 1'b1);
		write_reg(CFG_UNUSED, 7'h55);
		add_query(0, 0);
		add_query(1, 0);
		wait_drained();

		// random phases, each under its own geometry
		phase = 0;
		while (stim_count < 1500 || phase < 6) begin
			set_geometry(pick_dim(), pick_dim(), 1'($urandom));
			wide_values = 1'($urandom);
			steady = (phase == 2);
			if ($urandom_range(9) < 7)
				for (int t = 0; t < TAPS; t++)
					push_req(REQ_TAP, 4'(t), 6'($urandom), 6'($urandom), pick_value());
			if ($urandom_range(1))
				push_req(REQ_BIAS, 4'($urandom), 6'($urandom), 6'($urandom), pick_value());
			units = $urandom_range(60, 20);
			repeat (units) begin
				sel = $urandom_range(99);
				if (sel < 70) begin
					if (out_rows() > 0 && out_cols() > 0 && $urandom_range(4) != 0)
						add_query($urandom_range(out_rows() - 1), $urandom_range(out_cols() - 1));
					else
						add_query($urandom_range(63), $urandom_range(63));
				end else if (sel < 85) begin
					push_req(REQ_PIXEL, 4'($urandom), 6'($urandom), 6'($urandom), pick_value());
				end else if (sel < 95) begin
					push_req(REQ_TAP, 4'($urandom), 6'($urandom), 6'($urandom), pick_value());
				end else begin
					push_req(REQ_BIAS, 4'($urandom), 6'($urandom), 6'($urandom), pick_value());
				end
			end
			// long receiver stall while the sender keeps offering
			if (phase == 4) begin
				@(posedge clk);
				hold_cycles = 400;
			end
			wait_drained();
			phase++;
		end
		steady = 1'b0;

		$display("sent %0d requests over %0d plane geometries, %0d random phases",
			stim_count, settings, phase);
		$display("checked %0d in-range, %0d saturated and %0d outside-plane results",
			ok_count, sat_count, outside_count);
		if (mismatches == 0 && results_due.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// watchdog
	initial begin
		#(5_000_000);
		$display("TB_ERROR");
		$finish;
	end

endmodule
